### hdl/srns_pkg.sv
// shared types and constants for the refraction root solver
package srns_pkg;

  localparam int unsigned LenW = 24;
  localparam logic signed [63:0] SatLim = 64'sh3FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_DIV
  } alu_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  function automatic logic signed [63:0] sat_fn(input logic signed [65:0] v);
    if (v > 66'(SatLim)) begin
      return SatLim;
    end else if (v < -66'(SatLim)) begin
      return -SatLim;
    end
    return v[63:0];
  endfunction

endpackage

### hdl/srns_alu.sv
// shared multicycle arithmetic unit: saturating add/sub, q-format multiply, divide
module srns_alu #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  srns_pkg::alu_req_t    req,
  input  logic signed [63:0]    op_a,
  input  logic signed [63:0]    op_b,
  output logic                  done,
  output logic signed [63:0]    result
);

  localparam int unsigned IntLim = 25 - FRAC_BITS;
  localparam int unsigned CntW = 7;

  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                neg_r, neg_nxt;
  srns_pkg::alu_op_t   op_r, op_nxt;
  logic [63:0]         x_r, x_nxt;
  logic [63:0]         y_r, y_nxt;
  logic [127:0]        acc_r, acc_nxt;
  logic [63:0]         rem_r, rem_nxt;
  logic [63:0]         q_r, q_nxt;
  logic                ovf_r, ovf_nxt;
  logic                done_r, done_nxt;
  logic signed [63:0]  res_r, res_nxt;

  logic [63:0] mag_a, mag_b;
  logic [64:0] rem_sh;
  logic        ge;
  logic [63:0] pmag;
  logic [63:0] hi;
  logic [79:0] pprod;
  logic signed [65:0] sum;

  function automatic logic [63:0] SatLimU();
    return 64'(srns_pkg::SatLim);
  endfunction

  assign mag_a = op_a[63] ? 64'(-op_a) : op_a;
  assign mag_b = op_b[63] ? 64'(-op_b) : op_b;
  assign rem_sh = {rem_r, x_r[63]};
  assign ge = rem_sh >= {1'b0, y_r};
  assign hi = acc_r[127:64];
  assign pprod = x_r * y_r[15:0];

  always_comb begin
    pmag = '0;
    if ((hi >> FRAC_BITS) != 0) begin
      pmag = SatLimU();
    end else begin
      pmag = 64'(acc_r >> FRAC_BITS);
      if (pmag > SatLimU()) begin
        pmag = SatLimU();
      end
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    op_nxt   = op_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    ovf_nxt  = ovf_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    sum      = '0;
    if (req.start) begin
      op_nxt  = req.op;
      neg_nxt = op_a[63] ^ op_b[63];
      x_nxt   = mag_a;
      y_nxt   = mag_b;
      acc_nxt = '0;
      rem_nxt = '0;
      q_nxt   = '0;
      ovf_nxt = 1'b0;
      cnt_nxt = '0;
      unique case (req.op)
        srns_pkg::OP_ADD: begin
          sum      = 66'(op_a) + 66'(op_b);
          res_nxt  = srns_pkg::sat_fn(sum);
          done_nxt = 1'b1;
        end
        srns_pkg::OP_SUB: begin
          sum      = 66'(op_a) - 66'(op_b);
          res_nxt  = srns_pkg::sat_fn(sum);
          done_nxt = 1'b1;
        end
        default: busy_nxt = 1'b1;
      endcase
    end else if (busy_r) begin
      if (op_r == srns_pkg::OP_MUL) begin
        // 16 bits of the multiplier per cycle
        acc_nxt = acc_r + (128'(pprod) << (cnt_r[1:0] * 16));
        y_nxt   = y_r >> 16;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CntW'(3)) begin
          busy_nxt = 1'b0;
        end
      end else begin
        // restoring division, one bit per cycle, integer then fraction
        rem_nxt = ge ? 64'(rem_sh - {1'b0, y_r}) : rem_sh[63:0];
        x_nxt   = x_r << 1;
        q_nxt   = {q_r[62:0], ge};
        ovf_nxt = ovf_r | q_r[63];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CntW'(63 + FRAC_BITS)) begin
          busy_nxt = 1'b0;
        end
      end
    end else if (cnt_r != '0) begin
      cnt_nxt  = '0;
      done_nxt = 1'b1;
      if (op_r == srns_pkg::OP_MUL) begin
        res_nxt = neg_r ? -$signed(pmag) : $signed(pmag);
      end else if (ovf_r || ((q_r >> (FRAC_BITS + IntLim)) != 0)) begin
        res_nxt = neg_r ? -(64'sd1 <<< 25) : (64'sd1 <<< 25);
      end else begin
        res_nxt = neg_r ? -$signed(q_r) : $signed(q_r);
      end
    end
    if (!busy_r && !req.start && cnt_r == '0) begin
      done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    op_r  <= op_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    ovf_r <= ovf_nxt;
    res_r <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

### hdl/snell_refraction_newton_solver.sv
// refraction crossing radius solver: newton iterations on a shared arithmetic unit
// each transaction runs at most MAX_ITERATIONS newton iterations from input to output;
// multiplies and divides run one at a time on the one shared unit; early exit when |f|
// is below threshold ends a transaction sooner
// one transaction at a time: in_ready is low while solving
// rst_n synchronous active low: clears control, camera_height returns to 1.0
module snell_refraction_newton_solver #(
  parameter int unsigned MAX_ITERATIONS = 10,
  parameter int unsigned FRAC_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [23:0] cfg_camera_height,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_horizontal_distance,
  input  logic [23:0] in_point_depth,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_surface_radius
);

  localparam logic signed [63:0] OneQ = 64'sd1 <<< FRAC_BITS;
  localparam longint unsigned N1sqRaw = ((64'd1776889 << FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam logic signed [63:0] N1sqQ = 64'(N1sqRaw);
  localparam longint unsigned ThrRaw = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic signed [63:0] ThrQ = 64'(ThrRaw + ((ThrRaw == 0) ? 1 : 0));
  localparam logic signed [63:0] K2Q = 2 * (N1sqQ - OneQ);
  localparam int unsigned ItW = $clog2(MAX_ITERATIONS + 1);
  localparam int unsigned StW = 5;

  // register file slots
  typedef enum logic [4:0] {
    R_ZERO, R_H, R_D, R_RP, R_RS, R_H2, R_D2, R_E, R_E2, R_RS2,
    R_T, R_A, R_F, R_U, R_T1, R_T2, R_T3, R_FD, R_N1, R_K2
  } reg_id_t;

  typedef struct packed {
    srns_pkg::alu_op_t op;
    reg_id_t           a;
    reg_id_t           b;
    reg_id_t           dst;
  } micro_t;

  function automatic micro_t prog(input logic [StW-1:0] s);
    unique case (s)
      5'd0:  return '{srns_pkg::OP_SUB, R_RP, R_RS, R_E};
      5'd1:  return '{srns_pkg::OP_MUL, R_E, R_E, R_E2};
      5'd2:  return '{srns_pkg::OP_MUL, R_RS, R_RS, R_RS2};
      5'd3:  return '{srns_pkg::OP_ADD, R_H2, R_RS2, R_T};
      5'd4:  return '{srns_pkg::OP_MUL, R_N1, R_T, R_T};
      5'd5:  return '{srns_pkg::OP_SUB, R_T, R_RS2, R_A};
      5'd6:  return '{srns_pkg::OP_MUL, R_A, R_E2, R_T};
      5'd7:  return '{srns_pkg::OP_MUL, R_D2, R_RS2, R_U};
      5'd8:  return '{srns_pkg::OP_SUB, R_T, R_U, R_F};
      5'd9:  return '{srns_pkg::OP_MUL, R_K2, R_RS, R_T};
      5'd10: return '{srns_pkg::OP_MUL, R_T, R_E2, R_T1};
      5'd11: return '{srns_pkg::OP_ADD, R_A, R_A, R_T};
      5'd12: return '{srns_pkg::OP_MUL, R_T, R_E, R_T2};
      5'd13: return '{srns_pkg::OP_ADD, R_D2, R_D2, R_T};
      5'd14: return '{srns_pkg::OP_MUL, R_T, R_RS, R_T3};
      5'd15: return '{srns_pkg::OP_SUB, R_T1, R_T2, R_T};
      5'd16: return '{srns_pkg::OP_SUB, R_T, R_T3, R_FD};
      5'd17: return '{srns_pkg::OP_DIV, R_F, R_FD, R_T};
      5'd18: return '{srns_pkg::OP_MUL, R_H, R_H, R_H2};
      5'd19: return '{srns_pkg::OP_MUL, R_D, R_D, R_D2};
      default: return '{srns_pkg::OP_ADD, R_ZERO, R_ZERO, R_ZERO};
    endcase
  endfunction

  logic [23:0]        cam_r;
  srns_pkg::seq_state_t st_r, st_nxt;
  logic [StW-1:0]     pc_r, pc_nxt;
  logic [ItW-1:0]     it_r, it_nxt;
  logic signed [63:0] rf_r [20];
  logic [23:0]        res_r, res_nxt;

  micro_t             mi;
  srns_pkg::alu_req_t req;
  logic               alu_done;
  logic signed [63:0] alu_res;
  logic signed [63:0] opa, opb;
  logic signed [63:0] fdmag, rs_new;
  logic               wr_en;
  reg_id_t            wr_id;
  logic signed [63:0] wr_val;

  assign mi  = prog(pc_r);
  assign opa = rf_r[mi.a];
  assign opb = rf_r[mi.b];
  assign req = '{start: (st_r == srns_pkg::ST_ISSUE), op: mi.op};

  srns_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .op_a   (opa),
    .op_b   (opb),
    .done   (alu_done),
    .result (alu_res)
  );

  assign fdmag  = alu_res[63] ? -alu_res : alu_res;
  assign rs_new = rf_r[R_RS] - alu_res;

  always_comb begin
    st_nxt  = st_r;
    pc_nxt  = pc_r;
    it_nxt  = it_r;
    res_nxt = res_r;
    wr_en   = 1'b0;
    wr_id   = mi.dst;
    wr_val  = alu_res;
    unique case (st_r)
      srns_pkg::ST_IDLE: begin
        if (in_valid) begin
          st_nxt = srns_pkg::ST_ISSUE;
          pc_nxt = StW'(18);
          it_nxt = '0;
        end
      end
      srns_pkg::ST_ISSUE: st_nxt = srns_pkg::ST_WAIT;
      srns_pkg::ST_WAIT: begin
        if (alu_done) begin
          wr_en  = 1'b1;
          st_nxt = srns_pkg::ST_ISSUE;
          pc_nxt = pc_r + 1'b1;
          priority case (pc_r)
            StW'(19): pc_nxt = '0;
            StW'(0): begin
              if (it_r == ItW'(MAX_ITERATIONS)) begin
                wr_en   = 1'b0;
                res_nxt = rf_r[R_RS][23:0];
                st_nxt  = srns_pkg::ST_DONE;
              end
            end
            StW'(8): begin
              if ((alu_res[63] ? -alu_res : alu_res) < ThrQ) begin
                res_nxt = rf_r[R_RS][23:0];
                st_nxt  = srns_pkg::ST_DONE;
              end
            end
            StW'(16): begin
              if (fdmag < ThrQ) begin
                wr_val = -OneQ;
              end
            end
            StW'(17): begin
              wr_id  = R_RS;
              wr_val = rs_new;
              if (rs_new < 0) begin
                wr_val = '0;
              end else if (rs_new > rf_r[R_RP]) begin
                wr_val = rf_r[R_RP];
              end
              pc_nxt = '0;
              it_nxt = it_r + 1'b1;
            end
            default: ;
          endcase
        end
      end
      srns_pkg::ST_DONE: begin
        if (out_ready) begin
          st_nxt = srns_pkg::ST_IDLE;
        end
      end
      default: st_nxt = srns_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (st_r == srns_pkg::ST_IDLE);
    out_valid = (st_r == srns_pkg::ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= srns_pkg::ST_IDLE;
      cam_r <= 24'(OneQ);
      pc_r  <= '0;
      it_r  <= '0;
    end else begin
      st_r <= st_nxt;
      pc_r <= pc_nxt;
      it_r <= it_nxt;
      if (cfg_we) begin
        cam_r <= cfg_camera_height;
      end
    end
    res_r <= res_nxt;
    if (st_r == srns_pkg::ST_IDLE && in_valid) begin
      rf_r[R_ZERO] <= '0;
      rf_r[R_H]    <= 64'(cam_r);
      rf_r[R_D]    <= 64'(in_point_depth);
      rf_r[R_RP]   <= 64'(in_horizontal_distance);
      rf_r[R_RS]   <= 64'(in_horizontal_distance >> 1);
      rf_r[R_N1]   <= N1sqQ;
      rf_r[R_K2]   <= K2Q;
    end else if (wr_en) begin
      rf_r[wr_id] <= wr_val;
    end
  end

  assign out_surface_radius = res_r;

endmodule
